FILE: sv/erdf_pkg.sv
`default_nettype none

package erdf_pkg;

  localparam int unsigned DEPTH = 2048;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DELAY_W  = 12;
  localparam int unsigned GAP_W    = 32;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned FILL_W   = 12;
  localparam int unsigned CFG_W    = 32;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t FULL_CNT = cnt_t'(DEPTH);

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_DELAY     = 2'd1,
    CFG_BURST_GAP = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

FILE: sv/erdf_ram.sv
`default_nettype none

module erdf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/echo_reference_delay_fifo.sv
// Echo reference delay FIFO: one request (push, pop or clear) is taken every cycle.
// busy is never raised; a pop's result appears with done_o in the cycle after the beat.
// The sample store is a single-port-per-direction RAM with a registered read.
// Delay zeros are tracked by a counter and never written, so no clearing pass is needed.
// Reset empties the FIFO, forgets the last push time and clears all registers but the sample store.
// Results cannot be stalled by the receiver.
`default_nettype none

module echo_reference_delay_fifo (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            req_type_i,
  input  wire logic signed [erdf_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic                                  batch_start_i,
  input  wire logic [erdf_pkg::TIME_W-1:0]           now_us_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [1:0]                            cfg_index_i,
  input  wire logic [erdf_pkg::CFG_W-1:0]            cfg_wdata_i,
  output logic                                       done_o,
  output logic signed [erdf_pkg::SAMPLE_W-1:0]       ref_sample_o,
  output logic                                       underrun_o,
  output logic [erdf_pkg::FILL_W-1:0]                fill_level_o
);

  logic                              enable_q;
  logic [erdf_pkg::DELAY_W-1:0]      delay_q;
  logic [erdf_pkg::GAP_W-1:0]        gap_cfg_q;

  erdf_pkg::ptr_t                    rp_q, rp_d;
  erdf_pkg::cnt_t                    held_q, held_d;
  erdf_pkg::cnt_t                    zc_q, zc_d;
  logic [erdf_pkg::TIME_W-1:0]       last_q, last_d;
  logic                              seen_q, seen_d;

  logic                              done_q;
  logic                              zero_q;
  logic                              under_q;
  logic [erdf_pkg::FILL_W-1:0]       fill_q;

  logic                              accept;
  logic                              is_push, is_pop, is_clear;
  logic [erdf_pkg::TIME_W-1:0]       gap;
  logic                              new_burst;
  logic                              ram_we, ram_re;
  erdf_pkg::ptr_t                    ram_waddr;
  logic [erdf_pkg::SAMPLE_W-1:0]     ram_rdata;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_push  = accept && (req_type_i == erdf_pkg::REQ_PUSH) && enable_q;
  assign is_pop   = accept && (req_type_i == erdf_pkg::REQ_POP);
  assign is_clear = accept && (req_type_i == erdf_pkg::REQ_CLEAR);

  // Time wraps at 48 bits, so the gap is taken modulo that width.
  assign gap       = now_us_i - last_q;
  assign new_burst = !seen_q || (gap > {{(erdf_pkg::TIME_W - erdf_pkg::GAP_W){1'b0}}, gap_cfg_q});

  // The first zc_q entries from the read pointer are delay zeros that live only
  // in the counter; the RAM is read only for entries beyond them.
  always_comb begin
    erdf_pkg::ptr_t rp_t;
    erdf_pkg::cnt_t held_t;
    erdf_pkg::cnt_t zc_t;
    erdf_pkg::cnt_t dly;

    rp_t    = rp_q;
    held_t  = held_q;
    zc_t    = zc_q;
    dly     = erdf_pkg::FULL_CNT;
    last_d  = last_q;
    seen_d  = seen_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    ram_waddr = rp_q;

    if (32'(delay_q) <= 32'(erdf_pkg::DEPTH)) begin
      dly = erdf_pkg::cnt_t'(delay_q);
    end

    if (is_push) begin
      if (batch_start_i) begin
        last_d = now_us_i;
        seen_d = 1'b1;
        if ((held_q == '0) && new_burst && (delay_q != '0)) begin
          rp_t   = '0;
          held_t = dly;
          zc_t   = dly;
        end
      end
      if (held_t >= erdf_pkg::FULL_CNT) begin
        rp_t   = rp_t + 1'b1;
        held_t = erdf_pkg::FULL_CNT - 1'b1;
        if (zc_t != '0) begin
          zc_t = zc_t - 1'b1;
        end
      end
      ram_we    = 1'b1;
      ram_waddr = rp_t + held_t[erdf_pkg::PTR_W-1:0];
      held_t    = held_t + 1'b1;
    end else if (is_pop) begin
      if (held_q != '0) begin
        ram_re = (zc_q == '0);
        rp_t   = rp_q + 1'b1;
        held_t = held_q - 1'b1;
        if (zc_q != '0) begin
          zc_t = zc_q - 1'b1;
        end
      end
      if (held_t == '0) begin
        rp_t = '0;
      end
    end else if (is_clear) begin
      rp_t   = '0;
      held_t = '0;
      zc_t   = '0;
      last_d = '0;
      seen_d = 1'b0;
    end

    rp_d   = rp_t;
    held_d = held_t;
    zc_d   = zc_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      delay_q   <= '0;
      gap_cfg_q <= '0;
      rp_q      <= '0;
      held_q    <= '0;
      zc_q      <= '0;
      last_q    <= '0;
      seen_q    <= 1'b0;
      done_q    <= 1'b0;
      zero_q    <= 1'b0;
      under_q   <= 1'b0;
      fill_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          erdf_pkg::CFG_ENABLE:    enable_q  <= cfg_wdata_i[0];
          erdf_pkg::CFG_DELAY:     delay_q   <= cfg_wdata_i[erdf_pkg::DELAY_W-1:0];
          erdf_pkg::CFG_BURST_GAP: gap_cfg_q <= cfg_wdata_i[erdf_pkg::GAP_W-1:0];
          default: ;
        endcase
      end
      rp_q    <= rp_d;
      held_q  <= held_d;
      zc_q    <= zc_d;
      last_q  <= last_d;
      seen_q  <= seen_d;
      done_q  <= is_pop;
      if (is_pop) begin
        zero_q  <= (held_q == '0) || (zc_q != '0);
        under_q <= (held_q == '0);
        fill_q  <= erdf_pkg::FILL_W'(held_d);
      end
    end
  end

  erdf_ram #(
    .WIDTH(erdf_pkg::SAMPLE_W),
    .DEPTH(erdf_pkg::DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(sample_i),
    .re_i   (ram_re),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

  assign done_o       = done_q;
  assign ref_sample_o = zero_q ? '0 : $signed(ram_rdata);
  assign underrun_o   = under_q;
  assign fill_level_o = fill_q;

  a_zeros_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zc_q <= held_q) else $error("delay zero count exceeds fill level");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= erdf_pkg::FULL_CNT) else $error("fill level above depth");

  a_empty_ptr_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (rp_q == '0)) else $error("empty FIFO with nonzero read pointer");

  a_done_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_pop |=> done_o) else $error("pop beat without a result");

  a_underrun_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && underrun_o) |-> (fill_level_o == '0 && ref_sample_o == '0))
    else $error("underrun result carries data");

endmodule

`default_nettype wire
